### rtl/gregorian_date_register_defines.svh
// Assertion macros for the Gregorian date register.
// Depends on nothing; included by the top level only.
`ifndef GREGORIAN_DATE_REGISTER_DEFINES_SVH
`define GREGORIAN_DATE_REGISTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GDR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gdr: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gdr: next-cycle check failed");

`endif

### rtl/gdr_pkg.sv
// Package for the Gregorian date register: constants, tables, state type.
// No dependencies.
package gdr_pkg;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_SHIFT   = 2'd1;
    localparam logic [1:0] MODE_MEASURE = 2'd2;

    localparam logic [1:0] PASS_CUR   = 2'd0;
    localparam logic [1:0] PASS_GIVEN = 2'd1;
    localparam logic [1:0] PASS_FINAL = 2'd2;

    localparam logic [3:0]  DEF_MONTH = 4'd5;
    localparam logic [4:0]  DEF_DAY   = 5'd11;
    localparam logic [13:0] DEF_YEAR  = 14'd1959;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;

    // JDN of 0000-12-31 (day before 0001-01-01), and the legal JDN window
    localparam logic [22:0] JDN_BASE = 23'd1721425;
    localparam logic [22:0] JDN_MIN  = 23'd1721426;
    localparam logic [22:0] JDN_MAX  = 23'd5373484;

    // x/100 = (x*5243)>>19, exact for x < 16384
    localparam logic [12:0] Q100_MUL = 13'd5243;
    localparam int          Q100_SH  = 19;
    // years elapsed estimate = (n*2939750)>>30, n days since 0001-01-01
    localparam logic [21:0] YR_MUL = 22'd2939750;
    localparam int          YR_SH  = 30;
    // x/7 estimate (may be one low) = (x*9586980)>>26
    localparam logic [23:0] W7_MUL = 24'd9586980;
    localparam int          W7_SH  = 26;

    typedef enum logic [18:0] {
        S_IDLE  = 19'b0000000000000000001,
        S_GQ    = 19'b0000000000000000010,
        S_GCHK  = 19'b0000000000000000100,
        S_CINIT = 19'b0000000000000001000,
        S_CQ    = 19'b0000000000000010000,
        S_CLEAP = 19'b0000000000000100000,
        S_CQ2   = 19'b0000000000001000000,
        S_CDB   = 19'b0000000000010000000,
        S_DIST  = 19'b0000000000100000000,
        S_SHIFT = 19'b0000000001000000000,
        S_FEST  = 19'b0000000010000000000,
        S_FX    = 19'b0000000100000000000,
        S_FQ    = 19'b0000001000000000000,
        S_FCMP  = 19'b0000010000000000000,
        S_FQHI  = 19'b0000100000000000000,
        S_FCHI  = 19'b0001000000000000000,
        S_FMON  = 19'b0010000000000000000,
        S_WMUL  = 19'b0100000000000000000,
        S_WSUB  = 19'b1000000000000000000
    } t_state;

    // days before the first of month m in a common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
        logic [4:0] r;
        case (m)
            4'd2:    r = lp ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

### rtl/gregorian_date_register.sv
// Gregorian date register, top level; sequencer around one shared year unit.
// Depends on gdr_pkg and gregorian_date_register_defines.svh.
//
// Usage:
//  - Slave channel s_axis: one command item per handshake. tuser carries the
//    mode (load, shift, measure); tdata carries the given date and offset.
//  - Master channel m_axis: one result item per command, carrying the date
//    now held, its day number, weekday, day of year, leap flag, distance and
//    the validity and range flags.
//  - Each item runs through a small sequencer that reuses one year unit
//    (a multiply-by-reciprocal for /100 and the days-before-year sum).
//    Load and the unused mode run one day-number pass for the date held;
//    measure adds a pass for the given date; a shift in range adds a year
//    estimate with its correction steps (usually none or one) and a month
//    walk over up to 11 months, then a pass for the new date.
//  - s_axis_tready is high only when the sequencer is idle; one item at a
//    time. The result sits in an output register, so the next item is taken
//    while the result still waits; the sequencer stalls in its last step only
//    if a second result is ready before the first was taken.
//  - Reset (i_rst_n low, synchronous) sets the date to 1959-05-11, drops
//    m_axis_tvalid and returns the sequencer to idle.
//  - If the receiver stalls, m_axis_tvalid and m_axis_tdata hold.
module gregorian_date_register (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low bit up: given_month[3:0], given_day[8:4], given_year[22:9],
    // offset[45:23], zero pad[47:46]
    input  logic [47:0] s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low bit up: now_month[3:0], now_day[8:4], now_year[22:9],
    // day_number[45:23], weekday[48:46], year_day[57:49], leap[58],
    // distance[80:59], given_valid[81], out_of_range[82], zero pad[87:83]
    output logic [87:0] m_axis_tdata
);
    import gdr_pkg::*;

    t_state r_state;

    // current date (architectural state)
    logic [3:0]  r_cur_m;
    logic [4:0]  r_cur_d;
    logic [13:0] r_cur_y;

    // latched command
    logic [1:0]  r_mode;
    logic [3:0]  r_gm;
    logic [4:0]  r_gd;
    logic [13:0] r_gy;
    logic [22:0] r_off;
    logic [1:0]  r_pass;

    // shared year unit
    logic [13:0] r_x;
    logic [7:0]  r_q;
    logic [26:0] q_prod;
    logic [22:0] db_c;
    logic        leap_c;

    // working registers
    logic        r_lp;
    logic [22:0] r_jc;
    logic [22:0] r_jg;
    logic [8:0]  r_yday;
    logic        r_leap;
    logic [21:0] r_dist;
    logic        r_valid;
    logic        r_oor;
    logic [21:0] r_n;
    logic [46:0] r_prod;
    logic [22:0] r_lo;
    logic [8:0]  r_doy;
    logic [13:0] r_fy;
    logic        r_fleap;
    logic [3:0]  r_m;

    // output register
    logic        r_ovalid;
    logic [87:0] r_odata;

    // operand select for the date-to-day-number pass
    logic [3:0]  op_m;
    logic [4:0]  op_d;
    logic [13:0] op_y;
    logic [8:0]  op_before;
    logic [22:0] jv;
    logic        g_ok;
    logic [3:0]  next_m;
    logic [8:0]  cl_cur;
    logic [8:0]  cl_next;
    logic signed [24:0] nj;
    logic [20:0] q7;
    logic [22:0] rem7;
    logic [2:0]  wd;
    logic        out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign out_free      = !r_ovalid || m_axis_tready;

    // year unit: x/100, days in years 1..x, leap flag of year x
    assign q_prod = {13'd0, r_x} * {14'd0, Q100_MUL};
    assign db_c   = 23'({9'd0, r_x} * 23'd365) + 23'({9'd0, r_x} >> 2)
                  - {15'd0, r_q} + 23'({15'd0, r_q} >> 2);
    assign leap_c = (r_x[1:0] == 2'd0)
                  && ((r_x != 14'(r_q * 14'd100)) || (r_q[1:0] == 2'd0));

    assign g_ok = (r_gy >= 14'd1) && (r_gy <= YEAR_MAX)
               && (r_gm >= 4'd1) && (r_gm <= 4'd12)
               && (r_gd >= 5'd1) && (r_gd <= month_len(r_gm, leap_c));

    assign op_m = (r_pass == PASS_GIVEN) ? r_gm : r_cur_m;
    assign op_d = (r_pass == PASS_GIVEN) ? r_gd : r_cur_d;
    assign op_y = (r_pass == PASS_GIVEN) ? r_gy : r_cur_y;
    assign op_before = cum_days(op_m) + {8'd0, (op_m > 4'd2) && r_lp};
    assign jv = db_c + {14'd0, op_before} + {18'd0, op_d} + JDN_BASE;

    assign nj = $signed({2'b00, r_jc}) + $signed({{2{r_off[22]}}, r_off});

    // month walk for day-number-to-date
    assign next_m  = r_m + 4'd1;
    assign cl_cur  = cum_days(r_m) + {8'd0, (r_m > 4'd2) && r_fleap};
    assign cl_next = cum_days(next_m) + {8'd0, (next_m > 4'd2) && r_fleap};

    // weekday from the reciprocal estimate, one correction
    assign q7   = r_prod[W7_SH +: 21];
    assign rem7 = r_jc - 23'(q7 * 23'd7);
    assign wd   = (rem7 >= 23'd7) ? 3'(rem7 - 23'd7) : rem7[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur_m  <= DEF_MONTH;
            r_cur_d  <= DEF_DAY;
            r_cur_y  <= DEF_YEAR;
            r_pass   <= PASS_CUR;
            r_ovalid <= 1'b0;
        end else begin
            // a new result takes the output register, else a taken one leaves
            if (r_state == S_WSUB && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mode  <= s_axis_tuser;
                        r_gm    <= s_axis_tdata[3:0];
                        r_gd    <= s_axis_tdata[8:4];
                        r_gy    <= s_axis_tdata[22:9];
                        r_off   <= s_axis_tdata[45:23];
                        r_x     <= s_axis_tdata[22:9];
                        r_pass  <= PASS_CUR;
                        r_dist  <= '0;
                        r_valid <= 1'b0;
                        r_oor   <= 1'b0;
                        r_state <= S_GQ;
                    end
                end
                S_GQ: begin
                    r_q     <= q_prod[Q100_SH +: 8];
                    r_state <= S_GCHK;
                end
                S_GCHK: begin
                    // invalid given date falls back to the default date
                    if (!g_ok) begin
                        r_gm <= DEF_MONTH;
                        r_gd <= DEF_DAY;
                        r_gy <= DEF_YEAR;
                    end
                    if (r_mode == MODE_LOAD || r_mode == MODE_MEASURE) begin
                        r_valid <= g_ok;
                    end
                    if (r_mode == MODE_LOAD) begin
                        r_cur_m <= g_ok ? r_gm : DEF_MONTH;
                        r_cur_d <= g_ok ? r_gd : DEF_DAY;
                        r_cur_y <= g_ok ? r_gy : DEF_YEAR;
                    end
                    r_state <= S_CINIT;
                end
                S_CINIT: begin
                    r_x     <= op_y;
                    r_state <= S_CQ;
                end
                S_CQ: begin
                    r_q     <= q_prod[Q100_SH +: 8];
                    r_state <= S_CLEAP;
                end
                S_CLEAP: begin
                    r_lp    <= leap_c;
                    r_x     <= r_x - 14'd1;
                    r_state <= S_CQ2;
                end
                S_CQ2: begin
                    r_q     <= q_prod[Q100_SH +: 8];
                    r_state <= S_CDB;
                end
                S_CDB: begin
                    if (r_pass == PASS_GIVEN) begin
                        r_jg    <= jv;
                        r_state <= S_DIST;
                    end else begin
                        r_jc   <= jv;
                        r_yday <= op_before + {4'd0, op_d};
                        r_leap <= r_lp;
                        if (r_pass == PASS_CUR && r_mode == MODE_SHIFT) begin
                            r_state <= S_SHIFT;
                        end else if (r_pass == PASS_CUR && r_mode == MODE_MEASURE) begin
                            r_pass  <= PASS_GIVEN;
                            r_state <= S_CINIT;
                        end else begin
                            r_state <= S_WMUL;
                        end
                    end
                end
                S_DIST: begin
                    r_dist  <= (r_jc > r_jg) ? 22'(r_jc - r_jg) : 22'(r_jg - r_jc);
                    r_state <= S_WMUL;
                end
                S_SHIFT: begin
                    if (nj < $signed({2'b00, JDN_MIN}) || nj > $signed({2'b00, JDN_MAX})) begin
                        r_oor   <= 1'b1;
                        r_state <= S_WMUL;
                    end else begin
                        r_n     <= 22'(nj - $signed({2'b00, JDN_MIN}));
                        r_state <= S_FEST;
                    end
                end
                S_FEST: begin
                    r_prod  <= 47'({22'd0, r_n} * {22'd0, YR_MUL});
                    r_state <= S_FX;
                end
                S_FX: begin
                    r_x     <= r_prod[YR_SH +: 14];
                    r_state <= S_FQ;
                end
                S_FQ: begin
                    r_q     <= q_prod[Q100_SH +: 8];
                    r_state <= S_FCMP;
                end
                S_FCMP: begin
                    // estimate too high: step down
                    if (db_c > {1'b0, r_n}) begin
                        r_x     <= r_x - 14'd1;
                        r_state <= S_FQ;
                    end else begin
                        r_lo    <= db_c;
                        r_x     <= r_x + 14'd1;
                        r_state <= S_FQHI;
                    end
                end
                S_FQHI: begin
                    r_q     <= q_prod[Q100_SH +: 8];
                    r_state <= S_FCHI;
                end
                S_FCHI: begin
                    // r_x years elapsed bound; r_x itself is the year
                    if (db_c <= {1'b0, r_n}) begin
                        r_lo    <= db_c;
                        r_x     <= r_x + 14'd1;
                        r_state <= S_FQHI;
                    end else begin
                        r_doy   <= 9'({1'b0, r_n} - r_lo);
                        r_fy    <= r_x;
                        r_fleap <= leap_c;
                        r_m     <= 4'd1;
                        r_state <= S_FMON;
                    end
                end
                S_FMON: begin
                    if (r_m < 4'd12 && r_doy >= cl_next) begin
                        r_m <= next_m;
                    end else begin
                        r_cur_m <= r_m;
                        r_cur_d <= 5'(r_doy - cl_cur + 9'd1);
                        r_cur_y <= r_fy;
                        r_pass  <= PASS_FINAL;
                        r_state <= S_CINIT;
                    end
                end
                S_WMUL: begin
                    r_prod  <= 47'({24'd0, r_jc} * {23'd0, W7_MUL});
                    r_state <= S_WSUB;
                end
                S_WSUB: begin
                    if (out_free) begin
                        r_odata  <= {5'd0, r_oor, r_valid, r_dist, r_leap, r_yday, wd,
                                     r_jc, r_cur_y, r_cur_d, r_cur_m};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "gregorian_date_register_defines.svh"

    `GDR_ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, r_state == S_GQ)
    `GDR_ASSERT_NOW(a_cur_month_ok, 1'b1, r_cur_m >= 4'd1 && r_cur_m <= 4'd12)
    `GDR_ASSERT_NOW(a_flags_exclusive, m_axis_tvalid,
                    !(m_axis_tdata[82] && (m_axis_tdata[81] || m_axis_tdata[80:59] != 22'd0)))
    `GDR_ASSERT_NEXT(a_load_result, r_state == S_WSUB && out_free, m_axis_tvalid)

endmodule

### bench/tb_gregorian_date_register.sv
// Self-checking bench for the Gregorian date register: table of directed items, then random.
// Depends on gdr_pkg and the gregorian_date_register RTL.
module tb_gregorian_date_register;
    import gdr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTED   = 10;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // result item as carried on m_axis_tdata
    typedef struct packed {
        logic        out_of_range;
        logic        given_valid;
        logic [21:0] distance;
        logic        leap;
        logic [8:0]  year_day;
        logic [2:0]  weekday;
        logic [22:0] day_number;
        logic [13:0] now_year;
        logic [4:0]  now_day;
        logic [3:0]  now_month;
    } t_date_result;

    // command item
    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [13:0]        year;
        logic signed [22:0] offset;
    } t_date_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // month[3:0], day[8:4], year[22:9], offset[45:23]
    logic [1:0]  s_axis_tuser;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;   // see t_date_result, low field first

    gregorian_date_register u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state: the date it believes the block holds
    logic [3:0]  date_month;
    logic [4:0]  date_day;
    logic [13:0] date_year;

    t_date_result pending_results[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          timed_out;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          recv_hold;

    function automatic bit leap_year(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic bit date_valid(longint m, longint d, longint y);
        longint len;
        if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1) return 0;
        if (m == 2) len = leap_year(y) ? 29 : 28;
        else if (m == 4 || m == 6 || m == 9 || m == 11) len = 30;
        else len = 31;
        return d <= len;
    endfunction

    // Fliegel-Van Flandern, truncating division
    function automatic longint day_number_of(longint m, longint d, longint y);
        longint a;
        a = (m <= 2) ? 1 : 0;
        return d - 32075 + 1461 * (y + 4800 - a) / 4 + 367 * (m - 2 + 12 * a) / 12
             - 3 * ((y + 4900 - a) / 100) / 4;
    endfunction

    task automatic date_from_day_number(input longint jdn, output longint m,
                                        output longint d, output longint y);
        longint l, n, yy, mm, k;
        l = jdn + 68569;
        n = 4 * l / 146097;
        l = l - (146097 * n + 3) / 4;
        yy = 4000 * (l + 1) / 1461001;
        l = l - 1461 * yy / 4 + 31;
        mm = 80 * l / 2447;
        d = l - 2447 * mm / 80;
        k = mm / 11;
        m = mm + 2 - 12 * k;
        y = 100 * (n - 49) + yy + k;
    endtask

    // applies one command to the predicted date and returns the result item
    task automatic predict_date_step(input t_date_cmd c, output t_date_result r);
        longint gm, gd, gy, nj, m, d, y, a, b, jdn;
        bit ok;
        gm = longint'(c.month); gd = longint'(c.day); gy = longint'(c.year);
        ok = date_valid(gm, gd, gy);
        r = '0;
        if (!ok) begin
            gm = longint'(DEF_MONTH); gd = longint'(DEF_DAY); gy = longint'(DEF_YEAR);
        end
        case (c.mode)
            MODE_LOAD: begin
                date_month = 4'(gm); date_day = 5'(gd); date_year = 14'(gy);
                r.given_valid = ok;
            end
            MODE_SHIFT: begin
                nj = day_number_of(longint'(date_month), longint'(date_day),
                                   longint'(date_year)) + longint'(c.offset);
                if (nj < longint'(JDN_MIN) || nj > longint'(JDN_MAX)) begin
                    r.out_of_range = 1'b1;
                end else begin
                    date_from_day_number(nj, m, d, y);
                    date_month = 4'(m); date_day = 5'(d); date_year = 14'(y);
                end
            end
            MODE_MEASURE: begin
                a = day_number_of(longint'(date_month), longint'(date_day),
                                  longint'(date_year));
                b = day_number_of(gm, gd, gy);
                r.distance = 22'((a > b) ? a - b : b - a);
                r.given_valid = ok;
            end
            default: ;
        endcase
        jdn = day_number_of(longint'(date_month), longint'(date_day), longint'(date_year));
        r.now_month  = date_month;
        r.now_day    = date_day;
        r.now_year   = date_year;
        r.day_number = 23'(jdn);
        r.weekday    = 3'(jdn % 7);
        r.year_day   = 9'(jdn - day_number_of(1, 1, longint'(date_year)) + 1);
        r.leap       = leap_year(longint'(date_year));
    endtask

    // result side: compare each accepted item with the oldest expectation
    always @(posedge i_clk) begin
        t_date_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                    $display("unexpected result item %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // receiver ready, random idling or a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if (recv_hold) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // drive one command and wait for its handshake; predicts on acceptance
    task automatic send_date_cmd(input t_date_cmd c, input bit check_now,
                                 input t_date_result known);
        t_date_result r;
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.mode;
        s_axis_tdata  <= {2'b00, c.offset, c.year, c.day, c.month};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_date_step(c, r);
        if (check_now && r !== known) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
                $display("table row disagrees: typed %p, predicted %p", known, r);
        end
        pending_results.push_back(r);
        s_axis_tvalid <= 1'b0;
        // the block drops s_axis_tready after an accept anyway
        @(posedge i_clk);
    endtask

    // random command; mostly valid dates, offsets from small to full range
    function automatic t_date_cmd random_date_cmd();
        t_date_cmd c;
        c.mode   = $urandom_range(9) == 0 ? MODE_UNUSED : 2'($urandom_range(2));
        c.month  = 4'($urandom_range(4) == 0 ? $urandom_range(15) : $urandom_range(12, 1));
        c.day    = 5'($urandom_range(4) == 0 ? $urandom_range(31) : $urandom_range(31, 1));
        case ($urandom_range(3))
            0:       c.year = 14'($urandom_range(16383));
            1:       c.year = 14'($urandom_range(1, 9999));
            2:       c.year = 14'($urandom_range(10) == 0 ? 9999 : $urandom_range(1, 30));
            default: c.year = 14'($urandom_range(2400, 1500));
        endcase
        case ($urandom_range(3))
            0:       c.offset = 23'($urandom());
            1:       c.offset = $signed(23'($urandom_range(4000))) - 23'sd2000;
            2:       c.offset = $signed(23'($urandom_range(800000))) - 23'sd400000;
            default: c.offset = $signed(23'($urandom_range(7304116))) - 23'sd3652058;
        endcase
        return c;
    endfunction

    typedef struct {
        t_date_cmd    cmd;
        bit           typed;
        t_date_result known;
    } t_table_row;

    t_table_row date_table[$];

    function automatic t_table_row row(input logic [1:0] md, input int m, input int d,
                                       input int y, input int off);
        t_table_row t;
        t.cmd   = '{md, 4'(m), 5'(d), 14'(y), 23'(off)};
        t.typed = 1'b0;
        t.known = '0;
        return t;
    endfunction

    function automatic t_table_row typed_row(input t_table_row t, input t_date_result k);
        t.typed = 1'b1;
        t.known = k;
        return t;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_table_row t;
        mismatch_count = 0; idle_cycles = 0; timed_out = 0; recv_hold = 0;
        send_idle_pct = 34; recv_idle_pct = 76;
        date_month = DEF_MONTH; date_day = DEF_DAY; date_year = DEF_YEAR;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = MODE_LOAD;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; date after reset is 1959-05-11, JDN 2436700
        date_table.push_back(typed_row(row(MODE_SHIFT, 0, 0, 0, 0),
            '{1'b0, 1'b0, 22'd0, 1'b0, 9'd131, 3'd0, 23'd2436700, 14'd1959, 5'd11, 4'd5}));
        // invalid load falls back to the default date
        date_table.push_back(typed_row(row(MODE_LOAD, 15, 31, 16383, 0),
            '{1'b0, 1'b0, 22'd0, 1'b0, 9'd131, 3'd0, 23'd2436700, 14'd1959, 5'd11, 4'd5}));
        // earliest date
        date_table.push_back(typed_row(row(MODE_LOAD, 1, 1, 1, 0),
            '{1'b0, 1'b1, 22'd0, 1'b0, 9'd1, 3'd0, 23'd1721426, 14'd1, 5'd1, 4'd1}));
        date_table.push_back(row(MODE_SHIFT, 0, 0, 0, -1));        // below range
        date_table.push_back(row(MODE_SHIFT, 0, 0, 0, 3652058));   // to 9999-12-31
        date_table.push_back(row(MODE_SHIFT, 0, 0, 0, 1));         // above range
        date_table.push_back(row(MODE_MEASURE, 1, 1, 1, 0));       // largest distance
        date_table.push_back(row(MODE_SHIFT, 0, 0, 0, -4194304));  // offset extremes
        date_table.push_back(row(MODE_SHIFT, 0, 0, 0, 4194303));
        date_table.push_back(row(MODE_LOAD, 2, 29, 2000, 0));      // leap by 400
        date_table.push_back(row(MODE_LOAD, 2, 29, 1900, 0));      // not leap by 100
        date_table.push_back(row(MODE_LOAD, 2, 29, 2024, 0));
        date_table.push_back(row(MODE_SHIFT, 0, 0, 0, 366));
        date_table.push_back(row(MODE_LOAD, 4, 31, 2023, 0));      // day past month end
        date_table.push_back(row(MODE_LOAD, 13, 1, 2023, 0));      // bad month
        date_table.push_back(row(MODE_LOAD, 0, 5, 2023, 0));
        date_table.push_back(row(MODE_LOAD, 3, 0, 2023, 0));       // day zero
        date_table.push_back(row(MODE_LOAD, 1, 1, 0, 0));          // year zero
        date_table.push_back(row(MODE_LOAD, 12, 31, 9999, 0));
        date_table.push_back(row(MODE_MEASURE, 2, 30, 2020, 0));   // invalid measure
        date_table.push_back(row(MODE_MEASURE, 12, 31, 9999, 0));  // zero distance
        date_table.push_back(row(MODE_UNUSED, 7, 7, 7777, 77));
        date_table.push_back(row(MODE_SHIFT, 0, 0, 0, -2922));

        foreach (date_table[i]) begin
            t = date_table[i];
            send_date_cmd(t.cmd, t.typed, t.known);
        end

        // receiver holds off while items keep coming, so the block stalls
        wait_drained();
        recv_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int k = 0; k < 6; k++) send_date_cmd(random_date_cmd(), 0, '0);
        join

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 34 : 0;
            for (int k = 0; k < 125; k++) begin
                send_date_cmd(random_date_cmd(), 0, '0);
                if (k == 60) wait_drained();   // sender pauses until all results are back
            end
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
